[rtl/core/crrs_pkg.sv]
// ----------------------------------------------------------------------------
// crrs_pkg
// Shared types and codes for the command-parsed round-robin scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package crrs_pkg;

    // Input item selector
    localparam logic [1:0] CMD_RX_BYTE = 2'd0;
    localparam logic [1:0] CMD_TICK    = 2'd1;
    localparam logic [1:0] CMD_RUN     = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_TX     = 2'd0;
    localparam logic [1:0] KIND_SWITCH = 2'd1;
    localparam logic [1:0] KIND_PORT   = 2'd2;

    // ASCII codes seen by the parser
    localparam logic [7:0] CH_A  = 8'h41;
    localparam logic [7:0] CH_T  = 8'h54;
    localparam logic [7:0] CH_C  = 8'h43;
    localparam logic [7:0] CH_N  = 8'h4E;
    localparam logic [7:0] CH_S  = 8'h53;
    localparam logic [7:0] CH_Q  = 8'h51;
    localparam logic [7:0] CH_1  = 8'h31;
    localparam logic [7:0] CH_3  = 8'h33;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_O  = 8'h4F;
    localparam logic [7:0] CH_K  = 8'h4B;

    // Task data constants
    localparam logic [7:0] BCD_WRAP     = 8'h10;
    localparam logic [7:0] TOGGLE_RESET = 8'b10101010;
    localparam logic [7:0] RING_SEED    = 8'h01;

    // Task numbers
    localparam logic [1:0] TASK_NONE = 2'd0;
    localparam logic [1:0] TASK_BCD  = 2'd1;
    localparam logic [1:0] TASK_TOG  = 2'd2;
    localparam logic [1:0] TASK_RING = 2'd3;

    localparam int unsigned NUM_TASKS = 3;

    // Parser states
    typedef enum logic [2:0] {
        PS_IDLE  = 3'd0,
        PS_A     = 3'd1,
        PS_T     = 3'd2,
        PS_CLEAR = 3'd3,
        PS_STORE = 3'd4,
        PS_SET   = 3'd5,
        PS_QUIT  = 3'd6,
        PS_END   = 3'd7
    } t_pstate;

    // Request from the front end into the scheduler
    typedef struct packed {
        logic       valid;    // commit this request
        logic       tick;     // advance round-robin
        logic       run;      // execute current task
        logic       en_wr;    // write one enable flag
        logic [1:0] en_idx;   // flag index 0..2
        logic       en_val;   // new flag value
    } t_sched_req;

    // Scheduler response, valid in the same cycle as the request
    typedef struct packed {
        logic [1:0] cur_task;   // task selected now
        logic [1:0] next_task;  // task selected after a tick
        logic [7:0] port;       // port byte of a run step
        logic       run_ok;     // a task is selected
    } t_sched_rsp;

endpackage

`default_nettype wire

[rtl/core/command_parsed_round_robin_scheduler.sv]
// ----------------------------------------------------------------------------
// command_parsed_round_robin_scheduler
// Line parser, round-robin task scheduler and result sequencer.
// ----------------------------------------------------------------------------
// Each input request is a received byte, a time-slice tick or a run step,
// chosen by tuser. The whole effect of a request is worked out in the cycle
// it is accepted and written into the result register, so a request can be
// taken every cycle while results are drained. A tick or a run step gives
// one result; an LF closing a line gives four (O, K, CR, LF), which the
// single result register sends in turn, so such a request holds the input
// until its last result leaves. Other bytes and a run with no task give
// no result. The next request is taken in the cycle the final result of the
// previous one leaves. No clearing pass is needed after reset.
`default_nettype none

module command_parsed_round_robin_scheduler
    import crrs_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // slave side
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] rx_byte
    input  wire logic [1:0]  i_s_axis_tuser,   // [1:0] cmd
    // master side
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [23:0]      o_m_axis_tdata,   // [7:0] tx_byte, [9:8] current_task,
                                               // [17:10] port_value, [23:18] zero
    output logic [1:0]       o_m_axis_tuser,   // [1:0] kind
    output logic             o_m_axis_tlast    // last
);

    t_pstate    r_ps, n_ps;
    t_sched_req sreq;
    t_sched_rsp srsp;

    logic       in_fire;
    logic       line_done;
    logic       out_last;
    logic       out_fire;

    // result register
    logic       r_valid, n_valid;
    logic       r_reply, n_reply;
    logic [1:0] r_beat,  n_beat;
    logic [1:0] r_kind,  n_kind;
    logic [1:0] r_task,  n_task;
    logic [7:0] r_port,  n_port;
    logic [7:0] tx_byte;

    assign in_fire  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_last = !r_reply || (r_beat == 2'd3);
    assign out_fire = r_valid && i_m_axis_tready;

    assign o_s_axis_tready = !r_valid || (i_m_axis_tready && out_last);

    // parser state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ps <= PS_IDLE;
        end else begin
            r_ps <= n_ps;
        end
    end

    // parser next state and enable writes
    always_comb begin
        n_ps        = r_ps;
        line_done   = 1'b0;
        sreq.valid  = in_fire;
        sreq.tick   = (i_s_axis_tuser == CMD_TICK);
        sreq.run    = (i_s_axis_tuser == CMD_RUN);
        sreq.en_wr  = 1'b0;
        sreq.en_idx = i_s_axis_tdata[1:0] - CH_1[1:0];
        sreq.en_val = (r_ps == PS_SET);
        if (in_fire && (i_s_axis_tuser == CMD_RX_BYTE)) begin
            case (r_ps)
                PS_IDLE: begin
                    if (i_s_axis_tdata == CH_A)      n_ps = PS_A;
                    else if (i_s_axis_tdata == CH_C) n_ps = PS_CLEAR;
                    else if (i_s_axis_tdata == CH_N) n_ps = PS_STORE;
                    else if (i_s_axis_tdata == CH_S) n_ps = PS_SET;
                    else if (i_s_axis_tdata == CH_Q) n_ps = PS_QUIT;
                end
                PS_A: begin
                    if (i_s_axis_tdata == CH_T) n_ps = PS_T;
                end
                PS_SET, PS_QUIT: begin
                    if (i_s_axis_tdata inside {[CH_1:CH_3]}) begin
                        sreq.en_wr = 1'b1;
                    end else if (i_s_axis_tdata == CH_CR) begin
                        n_ps = PS_END;
                    end
                end
                PS_END: begin
                    if (i_s_axis_tdata == CH_LF) begin
                        n_ps      = PS_IDLE;
                        line_done = 1'b1;
                    end
                end
                default: begin
                    if (i_s_axis_tdata == CH_CR) n_ps = PS_END;
                end
            endcase
        end
    end

    crrs_sched u_sched (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (sreq),
        .o_rsp   (srsp)
    );

    // result register loading and beat sequencing
    always_comb begin
        n_valid = r_valid;
        n_reply = r_reply;
        n_beat  = r_beat;
        n_kind  = r_kind;
        n_task  = r_task;
        n_port  = r_port;
        if (in_fire) begin
            n_beat = 2'd0;
            n_port = 8'h00;
            case (i_s_axis_tuser)
                CMD_RX_BYTE: begin
                    n_valid = line_done;
                    n_reply = 1'b1;
                    n_kind  = KIND_TX;
                    n_task  = srsp.cur_task;
                end
                CMD_TICK: begin
                    n_valid = 1'b1;
                    n_reply = 1'b0;
                    n_kind  = KIND_SWITCH;
                    n_task  = srsp.next_task;
                end
                CMD_RUN: begin
                    n_valid = srsp.run_ok;
                    n_reply = 1'b0;
                    n_kind  = KIND_PORT;
                    n_task  = srsp.cur_task;
                    n_port  = srsp.port;
                end
                default: n_valid = 1'b0;
            endcase
        end else if (out_fire) begin
            if (out_last) begin
                n_valid = 1'b0;
            end else begin
                n_beat = r_beat + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_reply <= 1'b0;
            r_beat  <= 2'd0;
        end else begin
            r_valid <= n_valid;
            r_reply <= n_reply;
            r_beat  <= n_beat;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_task <= n_task;
        r_port <= n_port;
    end

    // OK CR LF reply bytes
    always_comb begin
        tx_byte = 8'h00;
        if (r_reply) begin
            case (r_beat)
                2'd0:    tx_byte = CH_O;
                2'd1:    tx_byte = CH_K;
                2'd2:    tx_byte = CH_CR;
                default: tx_byte = CH_LF;
            endcase
        end
    end

    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tdata  = {6'd0, r_port, r_task, tx_byte};
    assign o_m_axis_tuser  = r_kind;
    assign o_m_axis_tlast  = out_last;

endmodule

`default_nettype wire

[rtl/core/crrs_sched.sv]
// ----------------------------------------------------------------------------
// crrs_sched
// Task enable flags, round-robin selection and the three task data registers.
// ----------------------------------------------------------------------------
`default_nettype none

module crrs_sched
    import crrs_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_sched_req i_req,
    output t_sched_rsp      o_rsp
);

    logic [NUM_TASKS-1:0] r_en,   n_en;
    logic [1:0]           r_task, n_task;
    logic [7:0]           r_bcd,  n_bcd;
    logic [7:0]           r_tog,  n_tog;
    logic [7:0]           r_ring, n_ring;

    logic [1:0] next_sel;
    logic [1:0] cand;
    logic       found;
    logic [7:0] bcd_base;
    logic [7:0] ring_shift;
    logic [7:0] port;

    // Circular search starting after the current task
    always_comb begin
        next_sel = TASK_NONE;
        cand     = r_task;
        found    = 1'b0;
        for (int i = 0; i < NUM_TASKS; i++) begin
            cand = (cand == TASK_RING) ? TASK_BCD : cand + 2'd1;
            if (!found && r_en[cand - 2'd1]) begin
                next_sel = cand;
                found    = 1'b1;
            end
        end
    end

    // Task data updates and port byte
    always_comb begin
        bcd_base   = (r_bcd == BCD_WRAP) ? 8'h00 : r_bcd;
        ring_shift = {r_ring[6:0], 1'b0};
        n_bcd      = r_bcd;
        n_tog      = r_tog;
        n_ring     = r_ring;
        port       = 8'h00;
        case (r_task)
            TASK_BCD: begin
                port  = bcd_base;
                n_bcd = bcd_base + 8'd1;
            end
            TASK_TOG: begin
                n_tog = ~r_tog;
                port  = ~r_tog;
            end
            TASK_RING: begin
                n_ring = (ring_shift == 8'h00) ? RING_SEED : ring_shift;
                port   = n_ring;
            end
            default: port = 8'h00;
        endcase
    end

    // Next values of the control registers
    always_comb begin
        n_en   = r_en;
        n_task = r_task;
        if (i_req.valid && i_req.en_wr) begin
            n_en[i_req.en_idx] = i_req.en_val;
        end
        if (i_req.valid && i_req.tick) begin
            n_task = next_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en   <= '0;
            r_task <= TASK_NONE;
            r_bcd  <= 8'h00;
            r_tog  <= TOGGLE_RESET;
            r_ring <= 8'h00;
        end else begin
            r_en   <= n_en;
            r_task <= n_task;
            if (i_req.valid && i_req.run) begin
                r_bcd  <= n_bcd;
                r_tog  <= n_tog;
                r_ring <= n_ring;
            end
        end
    end

    assign o_rsp.cur_task  = r_task;
    assign o_rsp.next_task = next_sel;
    assign o_rsp.port      = port;
    assign o_rsp.run_ok    = (r_task != TASK_NONE);

endmodule

`default_nettype wire

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the command-parsed round-robin scheduler. Requests
// (received bytes, ticks, run steps) are sent on the slave stream. Each
// result on the master stream is compared with the oldest pending entry of a
// scoreboard. The entries come from a cycle-free model of the parser, the
// scheduler and the three tasks. A short table of directed requests comes
// first, followed by randomized command lines, ticks, run steps and noise.
// Random gaps and stalls are applied on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    import crrs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Select code the block ignores
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [7:0] CH_0       = 8'h30;

    localparam int RANDOM_ITEMS = 120;
    localparam int DRAIN_CYCLES = 16;
    localparam int NUM_DIRECTED = 26;

    // Reply bytes of a completed line
    localparam logic [7:0] OK_BYTES [4] = '{CH_O, CH_K, CH_CR, CH_LF};
    // Line openers, weighted toward enabling tasks
    localparam logic [7:0] LINE_OPS [7] = '{CH_A, CH_C, CH_N, CH_S, CH_S, CH_S, CH_Q};

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] tx_byte;
        logic [1:0] cur_task;
        logic [7:0] port_value;
        logic       last;
    } result_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] rx;
        logic       typed;    // expectation written in the row
        logic [1:0] kind;
        logic [1:0] sel;
        logic [7:0] port;
    } stim_row_t;

    // Directed requests; typed rows carry the result the block must give
    localparam stim_row_t DIRECTED [NUM_DIRECTED] = '{
        '{CMD_RUN,     8'h00, 1'b0, KIND_TX,     TASK_NONE, 8'h00},  // run with no task
        '{CMD_UNUSED,  8'hFF, 1'b0, KIND_TX,     TASK_NONE, 8'h00},  // ignored select
        '{CMD_TICK,    8'h00, 1'b1, KIND_SWITCH, TASK_NONE, 8'h00},
        '{CMD_RX_BYTE, CH_A,  1'b0, KIND_TX,     TASK_NONE, 8'h00},
        '{CMD_RX_BYTE, CH_T,  1'b0, KIND_TX,     TASK_NONE, 8'h00},
        '{CMD_RX_BYTE, CH_CR, 1'b0, KIND_TX,     TASK_NONE, 8'h00},
        '{CMD_RX_BYTE, CH_LF, 1'b1, KIND_TX,     TASK_NONE, 8'h00},
        '{CMD_RX_BYTE, CH_S,  1'b0, KIND_TX,     TASK_NONE, 8'h00},
        '{CMD_RX_BYTE, CH_1,  1'b0, KIND_TX,     TASK_NONE, 8'h00},
        '{CMD_RX_BYTE, CH_3,  1'b0, KIND_TX,     TASK_NONE, 8'h00},
        '{CMD_RX_BYTE, CH_CR, 1'b0, KIND_TX,     TASK_NONE, 8'h00},
        '{CMD_RX_BYTE, CH_LF, 1'b1, KIND_TX,     TASK_NONE, 8'h00},
        '{CMD_TICK,    8'h00, 1'b1, KIND_SWITCH, TASK_BCD,  8'h00},
        '{CMD_RUN,     8'h00, 1'b1, KIND_PORT,   TASK_BCD,  8'h00},
        '{CMD_TICK,    8'h00, 1'b1, KIND_SWITCH, TASK_RING, 8'h00},
        '{CMD_RUN,     8'h00, 1'b1, KIND_PORT,   TASK_RING, RING_SEED},
        '{CMD_RX_BYTE, CH_Q,  1'b0, KIND_TX,     TASK_NONE, 8'h00},
        '{CMD_RX_BYTE, CH_3,  1'b0, KIND_TX,     TASK_NONE, 8'h00},
        '{CMD_RX_BYTE, CH_CR, 1'b0, KIND_TX,     TASK_NONE, 8'h00},
        '{CMD_RX_BYTE, CH_LF, 1'b1, KIND_TX,     TASK_RING, 8'h00},
        '{CMD_TICK,    8'h00, 1'b1, KIND_SWITCH, TASK_BCD,  8'h00},
        '{CMD_RX_BYTE, CH_N,  1'b0, KIND_TX,     TASK_NONE, 8'h00},
        '{CMD_RX_BYTE, 8'h00, 1'b0, KIND_TX,     TASK_NONE, 8'h00},
        '{CMD_RX_BYTE, 8'hFF, 1'b0, KIND_TX,     TASK_NONE, 8'h00},
        '{CMD_RX_BYTE, CH_CR, 1'b0, KIND_TX,     TASK_NONE, 8'h00},
        '{CMD_RX_BYTE, CH_LF, 1'b0, KIND_TX,     TASK_NONE, 8'h00}
    };

    logic       clk;
    logic       rst_n   = 1'b0;
    logic       s_valid = 1'b0;
    logic [7:0] s_data  = '0;
    logic [1:0] s_user  = CMD_RX_BYTE;
    logic       m_ready = 1'b0;

    wire logic        o_s_axis_tready;
    wire logic        o_m_axis_tvalid;
    wire logic [23:0] o_m_axis_tdata;
    wire logic [1:0]  o_m_axis_tuser;
    wire logic        o_m_axis_tlast;

    // Scoreboard and counters
    result_t awaited_results [$];
    result_t step_out [$];
    int      mismatches = 0;
    int      items_sent = 0;
    int      src_calm   = 0;
    int      sink_calm  = 0;

    // Model state
    t_pstate    line_state  = PS_IDLE;
    logic [2:0] task_on     = '0;
    logic [1:0] sel_task    = TASK_NONE;
    logic [7:0] bcd_count   = 8'h00;
    logic [7:0] toggle_byte = TOGGLE_RESET;
    logic [7:0] ring_byte   = 8'h00;

    command_parsed_round_robin_scheduler dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // 100 MHz clock
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop
    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    // Gap length: mostly short, a few long, with calm stretches of no gaps
    function automatic int pick_gap(inout int calm_left);
        int roll;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm_left = $urandom_range(8, 30);
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 45) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    // Applies one accepted request to the model; its results land in step_out
    function automatic void step_scheduler(input logic [1:0] cmd, input logic [7:0] rx);
        t_pstate    nxt;
        logic [1:0] cand;
        logic       found;
        logic [7:0] port;
        step_out.delete();
        case (cmd)
            CMD_RX_BYTE: begin
                nxt = line_state;
                case (line_state)
                    PS_IDLE: begin
                        if (rx == CH_A) nxt = PS_A;
                        else if (rx == CH_C) nxt = PS_CLEAR;
                        else if (rx == CH_N) nxt = PS_STORE;
                        else if (rx == CH_S) nxt = PS_SET;
                        else if (rx == CH_Q) nxt = PS_QUIT;
                    end
                    PS_A: begin
                        if (rx == CH_T) nxt = PS_T;
                    end
                    PS_SET, PS_QUIT: begin
                        if (rx >= CH_1 && rx <= CH_3) task_on[rx - CH_1] = (line_state == PS_SET);
                        else if (rx == CH_CR) nxt = PS_END;
                    end
                    PS_END: begin
                        if (rx == CH_LF) begin
                            nxt = PS_IDLE;
                            for (int k = 0; k < 4; k++)
                                step_out.push_back('{KIND_TX, OK_BYTES[k], sel_task, 8'h00, k == 3});
                        end
                    end
                    default: begin
                        if (rx == CH_CR) nxt = PS_END;
                    end
                endcase
                line_state = nxt;
            end
            CMD_TICK: begin
                // search after the current task, ending with it
                cand  = sel_task;
                found = 1'b0;
                for (int i = 0; i < NUM_TASKS; i++) begin
                    cand = (cand == TASK_RING) ? TASK_BCD : cand + 2'd1;
                    if (!found && task_on[cand - 2'd1]) begin
                        sel_task = cand;
                        found    = 1'b1;
                    end
                end
                if (!found) sel_task = TASK_NONE;
                step_out.push_back('{KIND_SWITCH, 8'h00, sel_task, 8'h00, 1'b1});
            end
            CMD_RUN: begin
                if (sel_task != TASK_NONE) begin
                    case (sel_task)
                        TASK_BCD: begin
                            if (bcd_count == BCD_WRAP) bcd_count = 8'h00;
                            port      = bcd_count;
                            bcd_count = bcd_count + 8'd1;
                        end
                        TASK_TOG: begin
                            toggle_byte = ~toggle_byte;
                            port        = toggle_byte;
                        end
                        default: begin
                            ring_byte = ring_byte << 1;
                            if (ring_byte == 8'h00) ring_byte = RING_SEED;
                            port = ring_byte;
                        end
                    endcase
                    step_out.push_back('{KIND_PORT, 8'h00, sel_task, port, 1'b1});
                end
            end
            default: ;
        endcase
    endfunction

    // Drives one request, waits for acceptance, then updates the model
    task automatic send_request(input logic [1:0] cmd, input logic [7:0] rx);
        int gap;
        gap = pick_gap(src_calm);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_valid <= 1'b1;
        s_user  <= cmd;
        s_data  <= rx;
        @(posedge clk);
        while (!o_s_axis_tready) @(posedge clk);
        step_scheduler(cmd, rx);
        if (cmd != CMD_UNUSED) items_sent++;
    endtask

    // Request whose results come from the model
    task automatic post_request(input logic [1:0] cmd, input logic [7:0] rx);
        send_request(cmd, rx);
        foreach (step_out[k]) awaited_results.push_back(step_out[k]);
    endtask

    // Stimulus
    initial begin : stimulus
        stim_row_t  row;
        logic [7:0] line_bytes [$];
        logic [7:0] lead;
        int         pick;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed table
        for (int i = 0; i < NUM_DIRECTED; i++) begin
            row = DIRECTED[i];
            if (!row.typed) begin
                post_request(row.cmd, row.rx);
            end else begin
                send_request(row.cmd, row.rx);
                if (row.kind == KIND_TX) begin
                    for (int k = 0; k < 4; k++)
                        awaited_results.push_back('{KIND_TX, OK_BYTES[k], row.sel, 8'h00, k == 3});
                end else begin
                    awaited_results.push_back('{row.kind, 8'h00, row.sel, row.port, 1'b1});
                end
            end
        end

        // random part: mostly complete lines, plus ticks, runs and noise
        while (items_sent < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                line_bytes.delete();
                lead = LINE_OPS[$urandom_range(0, 6)];
                line_bytes.push_back(lead);
                if (lead == CH_A) begin
                    line_bytes.push_back(CH_T);
                end else if (lead == CH_N) begin
                    repeat ($urandom_range(0, 3))
                        line_bytes.push_back(CH_0 + 8'($urandom_range(0, 9)));
                end else if (lead == CH_S || lead == CH_Q) begin
                    repeat ($urandom_range(1, 3))
                        line_bytes.push_back(CH_1 + 8'($urandom_range(0, 2)));
                end
                // occasional stray byte and dropped LF break the line
                if ($urandom_range(0, 7) == 0)
                    line_bytes.insert($urandom_range(0, line_bytes.size() - 1), 8'($urandom));
                line_bytes.push_back(CH_CR);
                if ($urandom_range(0, 9) != 0) line_bytes.push_back(CH_LF);
                foreach (line_bytes[j]) post_request(CMD_RX_BYTE, line_bytes[j]);
            end else if (pick < 60) begin
                post_request(CMD_TICK, 8'($urandom));
            end else if (pick < 88) begin
                post_request(CMD_RUN, 8'($urandom));
            end else if (pick < 95) begin
                post_request(CMD_RX_BYTE, 8'($urandom));
            end else begin
                post_request(CMD_UNUSED, 8'($urandom));
            end
        end
        s_valid <= 1'b0;

        // drain, then watch for stray results
        while (awaited_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Result-side backpressure
    initial begin : sink_ready
        int stall;
        int run_len;
        while (!rst_n) @(posedge clk);
        forever begin
            stall = pick_gap(sink_calm);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_ready <= 1'b1;
            run_len = $urandom_range(1, 6);
            repeat (run_len) @(posedge clk);
        end
    end

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            mismatches++;
        end
    endfunction

    // Compare each accepted result with the oldest pending entry
    always @(posedge clk) begin : result_check
        result_t want;
        if (rst_n && o_m_axis_tvalid && m_ready) begin
            if (awaited_results.size() == 0) begin
                $error("unexpected result: tdata %h tuser %0d tlast %0b",
                       o_m_axis_tdata, o_m_axis_tuser, o_m_axis_tlast);
                mismatches++;
            end else begin
                want = awaited_results.pop_front();
                check_field("kind", want.kind, o_m_axis_tuser);
                check_field("tx_byte", want.tx_byte, o_m_axis_tdata[7:0]);
                check_field("current_task", want.cur_task, o_m_axis_tdata[9:8]);
                check_field("port_value", want.port_value, o_m_axis_tdata[17:10]);
                check_field("last", want.last, o_m_axis_tlast);
            end
        end
    end

endmodule

`default_nettype wire

[files.f]
rtl/core/crrs_pkg.sv
rtl/core/crrs_sched.sv
rtl/core/command_parsed_round_robin_scheduler.sv
verif/testbench.sv
